### rtl/pft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pft_pkg;

    // Event kinds carried in req_type
    typedef enum logic [1:0] {
        REQ_OVERFLOW = 2'd0,
        REQ_PPS      = 2'd1,
        REQ_FRAME    = 2'd2,
        REQ_GPS      = 2'd3
    } req_type_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEAP   = 2'd2;

    localparam logic [7:0] LIMIT_RESET   = 8'd183;
    localparam logic [7:0] LEAP_RESET    = 8'd18;
    localparam logic [7:0] NOTHING_SAVED = 8'hFF;

    // Status word layout
    localparam int unsigned ST_W       = 5;
    localparam int unsigned ST_SEEN    = 0;
    localparam int unsigned ST_RECENT  = 1;
    localparam int unsigned ST_SRC_LO  = 2;
    localparam int unsigned ST_SRC_HI  = 3;
    localparam int unsigned ST_JUMPED  = 4;

    // Leap source codes
    typedef enum logic [1:0] {
        SRC_UNKNOWN = 2'd0,
        SRC_DEFAULT = 2'd1,
        SRC_SAVED   = 2'd2,
        SRC_GPS     = 2'd3
    } leap_src_t;

    typedef struct packed {
        logic              frames_enabled;
        logic [7:0]        overflow_limit;
        logic signed [7:0] default_leap;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [15:0]       capture_count;
        logic [31:0]       gps_time;
        logic signed [7:0] gps_leap;
        logic              leap_is_default;
    } item_t;

    typedef struct packed {
        logic signed [7:0] frame_leap;
        logic [ST_W-1:0]   clock_status;
        logic [7:0]        frame_number;
        logic [31:0]       second_length;
        logic [31:0]       ticks_since_second;
        logic [31:0]       frame_epoch;
    } result_t;

    // Ticks from the PPS point to a capture, given whole overflows in between
    function automatic logic [31:0] span_ticks(input logic [7:0] ovf,
                                               input logic [15:0] cap,
                                               input logic [15:0] phase);
        logic [15:0] upper;
        upper = {8'h00, ovf} - 16'd1;
        return {upper, cap} + {16'h0000, phase};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

`default_nettype wire

### rtl/pps_frame_timestamper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame timestamper against a GPS pulse-per-second.
// Input channel (s_): one event per beat, kind in s_req_type: timer overflow
// tick, PPS capture, frame capture or GPS time/leap update. Only frame
// captures with frames_enabled set give a result beat on the m_ channel:
// leap, status, frame number, last second length, ticks since the PPS and
// the epoch second of the frame.
// Configuration: cfg_we/cfg_index/cfg_wdata write a register at once; write
// only while no event is in flight. Writing frames_enabled restarts the
// frame numbering.
// A result beat is presented from the result register: an accepted event waits
// in the input register, and its result is then loaded into the result register.
// Throughput: one event per cycle while m_ready does not stall the result stage,
// set by the state update between the two registers.
// Reset (aresetn low, synchronous): both stages empty, state and configuration
// to their defaults; s_ready is high as soon as the input stage is empty.
// Stall: while m_ready is low the result holds; one more event waits in the
// input register, and s_ready drops only when both are occupied.
module pps_frame_timestamper_top #(
    parameter int unsigned TICKS_PER_SECOND = 8000000
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [pft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pft_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_req_type,
    input  wire logic [15:0]                        s_capture_count,
    input  wire logic [31:0]                        s_gps_time,
    input  wire logic signed [7:0]                  s_gps_leap,
    input  wire logic                               s_leap_is_default,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [7:0]                       m_frame_leap,
    output logic [pft_pkg::ST_W-1:0]                m_clock_status,
    output logic [7:0]                              m_frame_number,
    output logic [31:0]                             m_second_length,
    output logic [31:0]                             m_ticks_since_second,
    output logic [31:0]                             m_frame_epoch
);

    pft_pkg::cfg_t    cfg;
    logic             counter_clear;
    pft_pkg::item_t   item_reg;
    logic             in_valid_reg;
    pft_pkg::result_t res;
    logic             res_valid;
    pft_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             advance;
    logic             in_take;

    pft_cfg_regs u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cfg           (cfg),
        .counter_clear (counter_clear)
    );

    pft_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .counter_clear (counter_clear),
        .fire          (advance),
        .item          (item_reg),
        .res           (res),
        .res_valid     (res_valid)
    );

    // Handshake: event moves on whenever the result slot is free or draining
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    // Input stage: capture the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            item_reg.req_type        <= s_req_type;
            item_reg.capture_count   <= s_capture_count;
            item_reg.gps_time        <= s_gps_time;
            item_reg.gps_leap        <= s_gps_leap;
            item_reg.leap_is_default <= s_leap_is_default;
        end
    end

    // Result stage: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_frame_leap         = out_reg.frame_leap;
    assign m_clock_status       = out_reg.clock_status;
    assign m_frame_number       = out_reg.frame_number;
    assign m_second_length      = out_reg.second_length;
    assign m_ticks_since_second = out_reg.ticks_since_second;
    assign m_frame_epoch        = out_reg.frame_epoch;

    // Both stages come out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_valid && !in_valid_reg))
        else $error("pipeline not empty after reset");

    // PPS recent is only ever set together with PPS seen, which never clears
    a_recent_implies_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_clock_status[pft_pkg::ST_SEEN] ||
                     !m_clock_status[pft_pkg::ST_RECENT]))
        else $error("status shows PPS recent without PPS seen");

    // A held event stays put while the result slot is blocked
    a_hold_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(item_reg)))
        else $error("blocked event lost or changed");

    // A result appears only when an event advanced in the previous cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance))
        else $error("result beat without an advancing event");

endmodule

`default_nettype wire

### rtl/pft_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pft_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [pft_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pft_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output pft_pkg::cfg_t                         cfg,
    output logic                                  counter_clear
);

    pft_pkg::cfg_t cfg_reg;

    // Decode writes; unknown indexes drop silently
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frames_enabled <= 1'b0;
            cfg_reg.overflow_limit <= pft_pkg::LIMIT_RESET;
            cfg_reg.default_leap   <= pft_pkg::LEAP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pft_pkg::CFG_FRAMES_ENABLED: cfg_reg.frames_enabled <= cfg_wdata[0];
                pft_pkg::CFG_OVERFLOW_LIMIT: cfg_reg.overflow_limit <= cfg_wdata;
                pft_pkg::CFG_DEFAULT_LEAP:   cfg_reg.default_leap   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
    // Any write to the enable restarts the frame sequence
    assign counter_clear = cfg_we && (cfg_index == pft_pkg::CFG_FRAMES_ENABLED);

endmodule

`default_nettype wire

### rtl/pft_core.sv
`timescale 1ns / 1ps
`default_nettype none

module pft_core #(
    parameter int unsigned TICKS_PER_SECOND = 8000000
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire pft_pkg::cfg_t   cfg,
    input  wire logic            counter_clear,
    input  wire logic            fire,
    input  wire pft_pkg::item_t  item,
    output pft_pkg::result_t     res,
    output logic                 res_valid
);

    logic [7:0]              overflow_count_reg, overflow_count_next;
    logic [15:0]             phase_comp_reg, phase_comp_next;
    logic [31:0]             last_second_reg, last_second_next;
    logic [1:0]              acquire_reg, acquire_next;
    logic [pft_pkg::ST_W-1:0] status_reg, status_next;
    logic [31:0]             utc_reg, utc_next;
    logic [7:0]              leap_now_reg, leap_now_next;
    logic [7:0]              saved_leap_reg, saved_leap_next;
    logic [7:0]              frame_counter_reg, frame_counter_next;

    logic [7:0]  ovf_inc;
    logic [31:0] span;
    logic [15:0] pps_point;
    logic        before_point;
    logic [31:0] ticks;
    logic [31:0] epoch;
    logic [7:0]  leap_sel;
    logic        is_frame;

    // Frame timing against the last PPS point
    always_comb begin
        ovf_inc      = overflow_count_reg + 8'd1;
        span         = pft_pkg::span_ticks(overflow_count_reg, item.capture_count,
                                           phase_comp_reg);
        pps_point    = ~phase_comp_reg;
        before_point = (overflow_count_reg == 8'd0) && (item.capture_count < pps_point);
        epoch        = before_point ? (utc_reg - 32'd1) : utc_reg;
        if (overflow_count_reg != 8'd0) begin
            ticks = span;
        end else if (before_point) begin
            ticks = last_second_reg - {16'h0000, pps_point - item.capture_count};
        end else begin
            ticks = {16'h0000, item.capture_count - pps_point};
        end
        leap_sel = (saved_leap_reg == pft_pkg::NOTHING_SAVED) ? cfg.default_leap
                                                              : saved_leap_reg;
    end

    // Next state for the event in hand
    always_comb begin
        overflow_count_next = overflow_count_reg;
        phase_comp_next     = phase_comp_reg;
        last_second_next    = last_second_reg;
        acquire_next        = acquire_reg;
        status_next         = status_reg;
        utc_next            = utc_reg;
        leap_now_next       = leap_now_reg;
        saved_leap_next     = saved_leap_reg;
        frame_counter_next  = frame_counter_reg;
        if (fire) begin
            unique case (pft_pkg::req_type_t'(item.req_type))
                pft_pkg::REQ_OVERFLOW: begin
                    overflow_count_next = ovf_inc;
                    if (ovf_inc >= cfg.overflow_limit) begin
                        status_next[pft_pkg::ST_RECENT] = 1'b0;
                        acquire_next = 2'd0;
                    end
                end
                pft_pkg::REQ_PPS: begin
                    utc_next            = utc_reg + 32'd1;
                    last_second_next    = span;
                    overflow_count_next = 8'd0;
                    phase_comp_next     = ~item.capture_count;
                    if (acquire_reg < 2'd2) begin
                        acquire_next = acquire_reg + 2'd1;
                        if (acquire_reg == 2'd1) begin
                            status_next[pft_pkg::ST_SEEN]   = 1'b1;
                            status_next[pft_pkg::ST_RECENT] = 1'b1;
                        end
                    end
                end
                pft_pkg::REQ_FRAME: begin
                    if (cfg.frames_enabled) begin
                        frame_counter_next = frame_counter_reg + 8'd1;
                    end
                end
                pft_pkg::REQ_GPS: begin
                    if (item.leap_is_default) begin
                        status_next[pft_pkg::ST_SRC_HI:pft_pkg::ST_SRC_LO] =
                            (saved_leap_reg == pft_pkg::NOTHING_SAVED) ?
                            pft_pkg::SRC_DEFAULT : pft_pkg::SRC_SAVED;
                        leap_now_next = leap_sel;
                        utc_next = item.gps_time - pft_pkg::sext8(leap_sel)
                                   + pft_pkg::sext8(item.gps_leap);
                    end else begin
                        status_next[pft_pkg::ST_SRC_HI:pft_pkg::ST_SRC_LO] =
                            pft_pkg::SRC_GPS;
                        saved_leap_next = item.gps_leap;
                        utc_next        = item.gps_time;
                        if (item.gps_leap != leap_now_reg) begin
                            status_next[pft_pkg::ST_JUMPED] = 1'b1;
                        end
                        leap_now_next = item.gps_leap;
                    end
                end
                default: ;
            endcase
        end
        if (counter_clear) begin
            frame_counter_next = 8'd0;
        end
    end

    // Hold the timekeeping state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overflow_count_reg <= 8'd0;
            phase_comp_reg     <= 16'd0;
            last_second_reg    <= 32'(TICKS_PER_SECOND);
            acquire_reg        <= 2'd0;
            status_reg         <= '0;
            utc_reg            <= 32'd0;
            leap_now_reg       <= pft_pkg::LEAP_RESET;
            saved_leap_reg     <= pft_pkg::NOTHING_SAVED;
            frame_counter_reg  <= 8'd0;
        end else begin
            overflow_count_reg <= overflow_count_next;
            phase_comp_reg     <= phase_comp_next;
            last_second_reg    <= last_second_next;
            acquire_reg        <= acquire_next;
            status_reg         <= status_next;
            utc_reg            <= utc_next;
            leap_now_reg       <= leap_now_next;
            saved_leap_reg     <= saved_leap_next;
            frame_counter_reg  <= frame_counter_next;
        end
    end

    assign is_frame  = (pft_pkg::req_type_t'(item.req_type) == pft_pkg::REQ_FRAME);
    assign res_valid = is_frame && cfg.frames_enabled;

    always_comb begin
        res.frame_leap         = leap_now_reg;
        res.clock_status       = status_reg;
        res.frame_number       = frame_counter_reg;
        res.second_length      = last_second_reg;
        res.ticks_since_second = ticks;
        res.frame_epoch        = epoch;
    end

endmodule

`default_nettype wire

### bench/pps_frame_timestamper_top_test.sv
`timescale 1ns / 1ps

module pps_frame_timestamper_top_test;
    import pft_pkg::*;

    localparam int unsigned TICKS        = 8000000;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned ITEM_TARGET  = 1450;
    localparam int unsigned MAX_REPORTS  = 10;
    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_req_type;
    logic [15:0]           s_capture_count;
    logic [31:0]           s_gps_time;
    logic signed [7:0]     s_gps_leap;
    logic                  s_leap_is_default;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [7:0]     m_frame_leap;
    logic [ST_W-1:0]       m_clock_status;
    logic [7:0]            m_frame_number;
    logic [31:0]           m_second_length;
    logic [31:0]           m_ticks_since_second;
    logic [31:0]           m_frame_epoch;

    pps_frame_timestamper_top #(
        .TICKS_PER_SECOND(TICKS)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_capture_count     (s_capture_count),
        .s_gps_time          (s_gps_time),
        .s_gps_leap          (s_gps_leap),
        .s_leap_is_default   (s_leap_is_default),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_frame_leap        (m_frame_leap),
        .m_clock_status      (m_clock_status),
        .m_frame_number      (m_frame_number),
        .m_second_length     (m_second_length),
        .m_ticks_since_second(m_ticks_since_second),
        .m_frame_epoch       (m_frame_epoch)
    );

    // Clock: 10 ns period
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Timestamper state as the bench expects it
    logic              frames_on;
    logic [7:0]        lost_after;
    logic signed [7:0] builtin_leap;
    logic [7:0]        ovf_since_pps;
    logic [15:0]       pps_comp;
    logic [31:0]       sec_ticks;
    logic [1:0]        acq_count;
    logic [ST_W-1:0]   clk_status;
    logic [31:0]       utc_now;
    logic signed [7:0] leap_in_force;
    logic signed [7:0] leap_saved;
    logic [7:0]        frame_seq;
    result_t           stamps_due[$];

    int unsigned mismatches     = 0;
    int unsigned stamps_checked = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned cfg_writes     = 0;
    int unsigned n_ovf = 0, n_pps = 0, n_frame = 0, n_gps = 0;

    // Idling controls for the sender and the receiver
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    logic        hold_request = 1'b0;

    function automatic void reset_clock_model();
        frames_on     = 1'b0;
        lost_after    = LIMIT_RESET;
        builtin_leap  = LEAP_RESET;
        ovf_since_pps = '0;
        pps_comp      = '0;
        sec_ticks     = TICKS;
        acq_count     = '0;
        clk_status    = '0;
        utc_now       = '0;
        leap_saved    = NOTHING_SAVED;
        leap_in_force = LEAP_RESET;
        frame_seq     = '0;
        stamps_due.delete();
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        cfg_writes++;
        case (idx)
            CFG_FRAMES_ENABLED: begin
                frames_on = data[0];
                frame_seq = '0;
            end
            CFG_OVERFLOW_LIMIT: lost_after = data;
            CFG_DEFAULT_LEAP:   builtin_leap = data;
            default: ;
        endcase
    endfunction

    // Advance the timestamper state by one event; queue a stamp for an enabled frame
    function automatic void timestamp_event(item_t ev);
        logic [31:0]       upper;
        logic [31:0]       ticks;
        logic [31:0]       epoch;
        logic [15:0]       point;
        logic [15:0]       gap;
        logic signed [7:0] gl;
        result_t           stamp;
        gl = ev.gps_leap;
        case (req_type_t'(ev.req_type))
            REQ_OVERFLOW: begin
                n_ovf++;
                ovf_since_pps = ovf_since_pps + 8'd1;
                if (ovf_since_pps >= lost_after) begin
                    clk_status[ST_RECENT] = 1'b0;
                    acq_count = '0;
                end
            end
            REQ_PPS: begin
                n_pps++;
                upper     = 32'(ovf_since_pps) - 32'd1;
                utc_now   = utc_now + 32'd1;
                sec_ticks = {upper[15:0], ev.capture_count} + 32'(pps_comp);
                ovf_since_pps = '0;
                pps_comp  = ~ev.capture_count;
                if (acq_count < 2'd2) begin
                    acq_count = acq_count + 2'd1;
                    if (acq_count == 2'd2) begin
                        clk_status[ST_SEEN]   = 1'b1;
                        clk_status[ST_RECENT] = 1'b1;
                    end
                end
            end
            REQ_GPS: begin
                n_gps++;
                if (ev.leap_is_default) begin
                    if (leap_saved == NOTHING_SAVED) begin
                        clk_status[ST_SRC_HI:ST_SRC_LO] = SRC_DEFAULT;
                        leap_in_force = builtin_leap;
                    end else begin
                        clk_status[ST_SRC_HI:ST_SRC_LO] = SRC_SAVED;
                        leap_in_force = leap_saved;
                    end
                    utc_now = ev.gps_time - 32'(int'(leap_in_force) - int'(gl));
                end else begin
                    clk_status[ST_SRC_HI:ST_SRC_LO] = SRC_GPS;
                    leap_saved = gl;
                    utc_now    = ev.gps_time;
                    if (gl != leap_in_force)
                        clk_status[ST_JUMPED] = 1'b1;
                    leap_in_force = gl;
                end
            end
            default: begin
                n_frame++;
                epoch = utc_now;
                if (ovf_since_pps == 8'd0) begin
                    point = ~pps_comp;
                    // Capture short of the PPS point: it belongs to the second before
                    if (ev.capture_count < point) begin
                        gap   = point - ev.capture_count;
                        ticks = sec_ticks - 32'(gap);
                        epoch = epoch - 32'd1;
                    end else begin
                        gap   = ev.capture_count - point;
                        ticks = 32'(gap);
                    end
                end else begin
                    upper = 32'(ovf_since_pps) - 32'd1;
                    ticks = {upper[15:0], ev.capture_count} + 32'(pps_comp);
                end
                if (frames_on) begin
                    stamp.frame_leap         = leap_in_force;
                    stamp.clock_status       = clk_status;
                    stamp.frame_number       = frame_seq;
                    stamp.second_length      = sec_ticks;
                    stamp.ticks_since_second = ticks;
                    stamp.frame_epoch        = epoch;
                    stamps_due.push_back(stamp);
                    frame_seq = frame_seq + 8'd1;
                end
            end
        endcase
    endfunction

    function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] stamp %0d: %s expected 0x%0h, got 0x%0h",
                         $time, stamps_checked, name, want, got);
        end
    endfunction

    function automatic void check_stamp();
        result_t want;
        if (stamps_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] stamp beat with none expected (frame number 0x%0h)",
                         $time, m_frame_number);
            return;
        end
        want = stamps_due.pop_front();
        note_field("frame_leap", 32'(want.frame_leap), 32'(m_frame_leap));
        note_field("clock_status", 32'(want.clock_status), 32'(m_clock_status));
        note_field("frame_number", 32'(want.frame_number), 32'(m_frame_number));
        note_field("second_length", want.second_length, m_second_length);
        note_field("ticks_since_second", want.ticks_since_second, m_ticks_since_second);
        note_field("frame_epoch", want.frame_epoch, m_frame_epoch);
        stamps_checked++;
    endfunction

    // Check result beats, then take register writes and input beats of this edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_clock_model();
        end else begin
            if (m_valid && m_ready)
                check_stamp();
            if (cfg_we)
                apply_reg_write(cfg_index, cfg_wdata);
            if (s_valid && s_ready)
                timestamp_event({s_req_type, s_capture_count, s_gps_time,
                                 s_gps_leap, s_leap_is_default});
        end
    end

    // Abandon a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d stamps outstanding",
                     cycle_count, stamps_due.size());
            $display("pps_frame_timestamper_top_test: FAIL");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic item_t make_event(req_type_t kind, logic [15:0] cap);
        item_t ev;
        ev.req_type        = kind;
        ev.capture_count   = cap;
        ev.gps_time        = $urandom();
        ev.gps_leap        = 8'($urandom_range(0, 255));
        ev.leap_is_default = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    function automatic item_t make_gps(logic [31:0] t, logic signed [7:0] leap,
                                       logic is_default);
        item_t ev;
        ev                 = make_event(REQ_GPS, 16'($urandom()));
        ev.gps_time        = t;
        ev.gps_leap        = leap;
        ev.leap_is_default = is_default;
        return ev;
    endfunction

    // Captures cluster round the PPS point and the timer extremes
    function automatic logic [15:0] pick_capture();
        logic [15:0] point;
        point = ~pps_comp;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return point + 16'($urandom_range(0, 4)) - 16'd2;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [7:0] pick_leap();
        case ($urandom_range(0, 7))
            0, 1:    return leap_in_force;
            2:       return 8'shFF;
            3:       return 8'sh80;
            4:       return 8'sh7F;
            5:       return LEAP_RESET;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one event beat; hold it until accepted, then maybe idle
    task automatic offer_event(input item_t ev);
        int unsigned pause;
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_req_type        <= ev.req_type;
        s_capture_count   <= ev.capture_count;
        s_gps_time        <= ev.gps_time;
        s_gps_leap        <= ev.gps_leap;
        s_leap_is_default <= ev.leap_is_default;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        pause = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
        if (pause > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (pause - 1) @(negedge aclk);
        end
    endtask

    task automatic send(input req_type_t kind, input logic [15:0] cap);
        offer_event(make_event(kind, cap));
    endtask

    task automatic wait_stamps_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (stamps_due.size() != 0) @(posedge aclk);
    endtask

    // Drain, then let events with no stamp clear the pipeline
    task automatic settle();
        wait_stamps_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] enable_word, input logic [7:0] limit,
                             input logic [7:0] leap);
        settle();
        write_reg(CFG_FRAMES_ENABLED, enable_word);
        write_reg(CFG_OVERFLOW_LIMIT, limit);
        write_reg(CFG_DEFAULT_LEAP, leap);
    endtask

    task automatic set_idling(input int unsigned gaps, input int unsigned stalls);
        @(posedge aclk);
        gap_pct   = gaps;
        stall_pct = stalls;
    endtask

    // Seconds: PPS, overflow ticks with frames between, GPS updates, stray events and drains
    task automatic run_seconds(input int unsigned stop_at);
        int unsigned ticks_left;
        int unsigned i;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 8) begin
                offer_event(make_event(req_type_t'($urandom_range(0, 3)), 16'($urandom())));
            end else if ($urandom_range(0, 99) < 2) begin
                wait_stamps_drained();
            end else begin
                send(REQ_PPS, 16'($urandom()));
                ticks_left = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40)
                                                          : $urandom_range(0, 3);
                for (i = 0; i <= ticks_left; i++) begin
                    repeat ($urandom_range(0, 2)) send(REQ_FRAME, pick_capture());
                    if ($urandom_range(0, 99) < 12)
                        offer_event(make_gps($urandom(), pick_leap(),
                                             1'($urandom_range(0, 1))));
                    if (i < ticks_left)
                        send(REQ_OVERFLOW, 16'($urandom()));
                end
            end
        end
    endtask

    task automatic test_reset_state();
        send(REQ_FRAME, 16'h1234);      // frames off after reset: no stamp
        configure(8'h01, LIMIT_RESET, LEAP_RESET);
        send(REQ_FRAME, 16'h0000);      // short of the PPS point: epoch wraps below zero
        send(REQ_FRAME, 16'hFFFF);      // exactly on the PPS point
    endtask

    task automatic test_events_directed();
        send(REQ_PPS, 16'h0000);        // no overflow since reset: length upper half wraps
        send(REQ_FRAME, 16'h8000);
        send(REQ_OVERFLOW, 16'h0000);
        send(REQ_FRAME, 16'hFFFF);
        send(REQ_PPS, 16'hFFFF);        // second PPS: seen and recent
        send(REQ_FRAME, 16'h0000);
        offer_event(make_gps(32'hFFFF_FFFF, 8'sh80, 1'b1));  // firmware leap, none saved
        send(REQ_FRAME, 16'h0001);
        offer_event(make_gps(32'h0000_0000, 8'sh7F, 1'b0));  // receiver leap differs: jump
        send(REQ_FRAME, 16'h7FFF);
        offer_event(make_gps(32'h5A5A_A5A5, 8'sh00, 1'b1));  // saved value takes over
        send(REQ_FRAME, 16'hC000);
        offer_event(make_gps(32'h1234_5678, 8'shFF, 1'b0));  // minus one reads as none saved
        offer_event(make_gps(32'h8765_4321, 8'sh03, 1'b1));  // back to the built-in leap
        send(REQ_FRAME, 16'h4000);
    endtask

    task automatic test_config_extremes();
        // Zero limit: every overflow tick loses the PPS
        configure(8'h01, 8'd0, 8'h80);
        send(REQ_PPS, 16'h1000);
        send(REQ_PPS, 16'h2000);
        send(REQ_FRAME, 16'h2100);
        send(REQ_OVERFLOW, 16'h0000);
        send(REQ_FRAME, 16'h0100);
        offer_event(make_gps(32'h0000_0100, 8'shFF, 1'b0));
        offer_event(make_gps(32'h0000_0200, 8'sh05, 1'b1));
        send(REQ_FRAME, 16'h0200);
        configure(8'h01, 8'd255, 8'h7F);
        write_reg(CFG_UNUSED, 8'hA5);   // no register here: ignore
        offer_event(make_gps(32'hFFFF_FFF0, 8'sh80, 1'b1));
        send(REQ_FRAME, 16'hFFFE);
        send(REQ_FRAME, 16'h0003);
        // Rewrite enable: numbering restarts
        settle();
        write_reg(CFG_FRAMES_ENABLED, 8'hFF);
        send(REQ_FRAME, 16'h5555);
        settle();
        write_reg(CFG_FRAMES_ENABLED, 8'hFE);
        send(REQ_FRAME, 16'hAAAA);
        settle();
        write_reg(CFG_FRAMES_ENABLED, 8'h01);
        send(REQ_FRAME, 16'h0F0F);
    endtask

    task automatic test_overflow_wrap();
        configure(8'h01, 8'd255, LEAP_RESET);
        set_idling(10, 10);
        send(REQ_PPS, 16'h4000);
        repeat (256) send(REQ_OVERFLOW, 16'($urandom()));   // count wraps to zero
        send(REQ_FRAME, 16'h3000);
        send(REQ_PPS, 16'h5000);
        send(REQ_FRAME, 16'h6000);
    endtask

    task automatic test_backpressure();
        int unsigned n;
        configure(8'h01, LIMIT_RESET, LEAP_RESET);
        set_idling(0, 0);
        // Hold the receiver off while frames keep coming
        hold_request = 1'b1;
        for (n = 0; n < 24; n++) begin
            if (n % 8 == 0)
                send(REQ_PPS, 16'($urandom()));
            send(REQ_FRAME, pick_capture());
        end
        wait_stamps_drained();
        repeat (3) send(REQ_FRAME, pick_capture());
    endtask

    task automatic random_phase(input logic [7:0] enable_word, input logic [7:0] limit,
                                input logic [7:0] leap, input int unsigned gaps,
                                input int unsigned stalls, input int unsigned count);
        configure(enable_word, limit, leap);
        set_idling(gaps, stalls);
        run_seconds(items_sent + count);
    endtask

    task automatic test_random();
        int unsigned share;
        share = (ITEM_TARGET > items_sent + 120) ? (ITEM_TARGET - items_sent) / 6 : 20;
        random_phase(8'h01, LIMIT_RESET, LEAP_RESET, 30, 30, share);
        random_phase(8'h01, 8'd3, 8'hFF, 0, 0, share);
        random_phase(8'h00, 8'd1, 8'h05, 20, 20, share / 2);
        random_phase(8'h01, 8'd255, 8'h7F, 50, 50, share);
        random_phase(8'h01, 8'($urandom_range(1, 10)), 8'($urandom()), 30, 30, share);
        random_phase(8'h01, 8'd0, 8'h80, 20, 40, share + share / 2);
    endtask

    initial begin
        aresetn           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_req_type        = REQ_OVERFLOW;
        s_capture_count   = '0;
        s_gps_time        = '0;
        s_gps_leap        = '0;
        s_leap_is_default = 1'b0;
        m_ready           = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_events_directed();
        test_config_extremes();
        test_overflow_wrap();
        test_backpressure();
        test_random();
        settle();

        $display("events: %0d overflow ticks, %0d PPS, %0d frames, %0d GPS updates",
                 n_ovf, n_pps, n_frame, n_gps);
        $display("%0d timestamps checked, %0d register writes, %0d mismatches",
                 stamps_checked, cfg_writes, mismatches);
        if (mismatches == 0 && stamps_due.size() == 0)
            $display("pps_frame_timestamper_top_test: PASS");
        else
            $display("pps_frame_timestamper_top_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/pft_pkg.sv
rtl/pft_cfg_regs.sv
rtl/pft_core.sv
rtl/pps_frame_timestamper_top.sv
bench/pps_frame_timestamper_top_test.sv
